/* rtl/ittf_pkg.sv */
package ittf_pkg;

  // value width and field limits
  localparam int VALUE_BITS  = 32;
  localparam int MAX_FIELD   = 60;
  localparam int FIELD_W     = 6;
  localparam int RADIX_W     = 6;
  localparam int RADIX_MIN   = 2;
  localparam int RADIX_MAX   = 36;

  // base-b digit cells, one per bit of the value (enough for base 2)
  localparam int NUM_CELLS   = VALUE_BITS;
  localparam int CELL_W      = 6;
  localparam int CELL_IDX_W  = $clog2(NUM_CELLS);
  localparam int LEN_W       = $clog2(NUM_CELLS + 1);
  localparam int CNT_W       = $clog2(VALUE_BITS);

  localparam int POS_W       = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // ASCII codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

  typedef logic [CELL_W-1:0] digit_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_FIN,
    FE_PUSH
  } fe_state_t;

  // one formatted job: digit cells plus segment end positions
  typedef struct packed {
    logic                         bad;
    digit_t [NUM_CELLS-1:0]       digits;
    pos_t                         end_lead;
    pos_t                         end_sign;
    pos_t                         end_prefix;
    pos_t                         end_zeros;
    pos_t                         end_digits;
    pos_t                         total;
    logic [7:0]                   sign_char;
    logic [7:0]                   x_char;
    logic                         lower;
  } job_t;

  function automatic logic [7:0] digit_char(digit_t d, logic lower);
    logic [7:0] letter_base;
    letter_base = lower ? CH_LOWER_A : CH_UPPER_A;
    if (d < 6'd10) begin
      return CH_ZERO + {2'b00, d};
    end else begin
      return letter_base + {2'b00, d} - 8'd10;
    end
  endfunction

endpackage

/* rtl/ittf_ifs.sv */
interface ittf_in_if import ittf_pkg::*; ;
  logic                        valid;
  logic                        ready;
  logic signed [VALUE_BITS-1:0] value;
  logic [RADIX_W-1:0]          radix;
  logic [FIELD_W-1:0]          text_width;
  logic [FIELD_W-1:0]          min_digits;
  logic                        left_justify;
  logic                        force_plus;
  logic                        space_sign;
  logic                        alt_prefix;
  logic                        zero_fill;
  logic                        lower_case;
  logic                        is_signed;

  modport source (
    output valid, value, radix, text_width, min_digits, left_justify,
           force_plus, space_sign, alt_prefix, zero_fill, lower_case, is_signed,
    input  ready
  );
  modport sink (
    input  valid, value, radix, text_width, min_digits, left_justify,
           force_plus, space_sign, alt_prefix, zero_fill, lower_case, is_signed,
    output ready
  );
endinterface

interface ittf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;
  logic       bad_radix;

  modport source (output valid, out_char, last_char, bad_radix, input ready);
  modport sink   (input valid, out_char, last_char, bad_radix, output ready);
endinterface

/* rtl/integer_to_text_formatter.sv */
// Flow: a valid item is converted one bit per cycle over all value bits, then
//   its segment ends are worked out and it is queued; a bad radix skips both.
// The front takes no new item until the last one is pushed; the back emits one
//   character per cycle while the receiver is ready, after a pop that loads
//   each run (run length at most 63).
// Reset: synchronous active-low rst_n clears the front FSM, queue and output valid.
module integer_to_text_formatter import ittf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ittf_in_if.sink     in_if,
  ittf_out_if.source  out_if
);

  // Front: takes a transaction, forms sign and magnitude, converts the
  // magnitude into base-b digit cells MSB first, then works out where
  // each text segment ends (leading spaces, sign, prefix, zeros, digits,
  // trailing spaces).
  logic push, q_full, q_valid, pop;
  job_t push_job, pop_job;

  ittf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  // Two-entry job queue lets conversion of the next item overlap with
  // emission of the current run.
  ittf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_job  (pop_job)
  );

  // Back: walks a position counter through the segments and emits one character
  // transaction per cycle while the receiver is ready, through an output register.
  ittf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (pop_job),
    .pop     (pop),
    .out_if  (out_if)
  );

endmodule

/* rtl/ittf_front.sv */
module ittf_front import ittf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ittf_in_if.sink     in_if,
  output logic        push,
  output job_t        push_job,
  input  logic        q_full
);

  fe_state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0]  mag_r;
  digit_t [NUM_CELLS-1:0] cells_r, cells_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic [RADIX_W-1:0]     radix_r;
  logic [FIELD_W-1:0]     fw_r, md_r;
  logic                   left_r, alt_r, zfill_r, lower_r;
  logic [7:0]             sign_char_r;
  logic                   has_sign_r;
  job_t                   job_r, job_nxt;

  logic [NUM_CELLS:0]     carry;
  logic                   accept, radix_bad, neg;

  assign accept    = in_if.valid && in_if.ready;
  assign radix_bad = (in_if.radix < RADIX_W'(RADIX_MIN)) ||
                     (in_if.radix > RADIX_W'(RADIX_MAX));
  assign neg       = in_if.is_signed && in_if.value[VALUE_BITS-1];

  // one value bit per cycle into the base-b cells: cells = cells*2 + bit
  always_comb begin
    logic       gen, prop;
    logic [6:0] t;
    carry[0] = mag_r[VALUE_BITS-1];
    for (int i = 0; i < NUM_CELLS; i++) begin
      gen          = {cells_r[i], 1'b0} >= {1'b0, radix_r};
      prop         = {cells_r[i], 1'b1} == {1'b0, radix_r};
      carry[i+1]   = gen || (prop && carry[i]);
      t            = {cells_r[i], carry[i]} - (carry[i+1] ? {1'b0, radix_r} : 7'd0);
      cells_nxt[i] = t[CELL_W-1:0];
    end
    len_nxt = len_r + {{(LEN_W-1){1'b0}}, carry[len_r]};
  end

  // segment lengths once the digits are known
  always_comb begin
    logic [POS_W-1:0]   nd, size_c, prec_c, prec_eff, padn, lead, zeros, trail;
    logic [1:0]         pl;
    logic [POS_W+1:0]   rest;
    logic               zpad;
    nd       = (len_r == '0) ? POS_W'(1) : POS_W'(len_r);
    size_c   = (fw_r > FIELD_W'(MAX_FIELD)) ? POS_W'(MAX_FIELD) : fw_r;
    prec_c   = (md_r > FIELD_W'(MAX_FIELD)) ? POS_W'(MAX_FIELD) : md_r;
    prec_eff = (prec_c > nd) ? prec_c : nd;
    pl       = !alt_r ? 2'd0 : (radix_r == RADIX_HEX) ? 2'd2 :
               (radix_r == RADIX_OCT) ? 2'd1 : 2'd0;
    rest     = {2'b00, size_c} - {{(POS_W+1){1'b0}}, has_sign_r}
               - {{POS_W{1'b0}}, pl} - {2'b00, prec_eff};
    padn     = (rest[POS_W+1] || rest == '0) ? '0 : rest[POS_W-1:0];
    zpad     = zfill_r && !left_r;
    lead     = (!zpad && !left_r) ? padn : '0;
    zeros    = (zpad ? padn : '0) + (prec_eff - nd);
    trail    = left_r ? padn : '0;

    job_nxt            = job_r;
    job_nxt.bad        = 1'b0;
    job_nxt.digits     = cells_r;
    job_nxt.end_lead   = lead;
    job_nxt.end_sign   = lead + POS_W'(has_sign_r);
    job_nxt.end_prefix = job_nxt.end_sign + POS_W'(pl);
    job_nxt.end_zeros  = job_nxt.end_prefix + zeros;
    job_nxt.end_digits = job_nxt.end_zeros + nd;
    job_nxt.total      = job_nxt.end_digits + trail;
    job_nxt.sign_char  = sign_char_r;
    job_nxt.x_char     = lower_r ? CH_LOWER_X : CH_UPPER_X;
    job_nxt.lower      = lower_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_if.ready = 1'b0;
    push        = 1'b0;
    unique case (state_r)
      FE_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          state_nxt = radix_bad ? FE_PUSH : FE_CONV;
        end
      end
      FE_CONV: begin
        if (cnt_r == '0) begin
          state_nxt = FE_FIN;
        end
      end
      FE_FIN: begin
        state_nxt = FE_PUSH;
      end
      FE_PUSH: begin
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  assign push_job = job_r;

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r       <= neg ? (~in_if.value + 1'b1) : in_if.value;
      cells_r     <= '0;
      len_r       <= '0;
      cnt_r       <= CNT_W'(VALUE_BITS - 1);
      radix_r     <= in_if.radix;
      fw_r        <= in_if.text_width;
      md_r        <= in_if.min_digits;
      left_r      <= in_if.left_justify;
      alt_r       <= in_if.alt_prefix;
      zfill_r     <= in_if.zero_fill;
      lower_r     <= in_if.lower_case;
      has_sign_r  <= neg || in_if.force_plus || in_if.space_sign;
      sign_char_r <= neg ? CH_MINUS : in_if.force_plus ? CH_PLUS : CH_SPACE;
      job_r.bad   <= radix_bad;
    end else if (state_r == FE_CONV) begin
      mag_r   <= {mag_r[VALUE_BITS-2:0], 1'b0};
      cells_r <= cells_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_r - 1'b1;
    end else if (state_r == FE_FIN) begin
      job_r <= job_nxt;
    end
  end

endmodule

/* rtl/ittf_queue.sv */
module ittf_queue import ittf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output job_t pop_job
);

  job_t               entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign pop_job = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("job queue underflow");

  a_ptrs_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r)) else $error("queue pointers out of step");

endmodule

/* rtl/ittf_back.sv */
module ittf_back import ittf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        pop,
  ittf_out_if.source  out_if
);

  job_t       job_r;
  logic       busy_r;
  pos_t       pos_r;
  logic       out_valid_r;
  logic [7:0] char_r;
  logic       last_r, bad_r;

  logic       out_free, emit, is_last;
  logic [7:0] ch;
  logic [CELL_IDX_W-1:0] didx;

  assign out_free = !out_valid_r || out_if.ready;
  assign emit     = busy_r && out_free;
  assign pop      = !busy_r && q_valid;
  assign is_last  = job_r.bad || (pos_r == job_r.total - 1'b1);
  assign didx     = CELL_IDX_W'(job_r.end_digits - pos_r - 1'b1);

  // character at the current position, segment by segment
  always_comb begin
    priority if (job_r.bad) begin
      ch = CH_NUL;
    end else if (pos_r < job_r.end_lead) begin
      ch = CH_SPACE;
    end else if (pos_r < job_r.end_sign) begin
      ch = job_r.sign_char;
    end else if (pos_r < job_r.end_prefix) begin
      ch = (pos_r == job_r.end_sign) ? CH_ZERO : job_r.x_char;
    end else if (pos_r < job_r.end_zeros) begin
      ch = CH_ZERO;
    end else if (pos_r < job_r.end_digits) begin
      ch = digit_char(job_r.digits[didx], job_r.lower);
    end else begin
      ch = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
      end else if (emit && is_last) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_job;
      pos_r <= '0;
    end else if (emit) begin
      pos_r <= pos_r + 1'b1;
    end
    if (emit) begin
      char_r <= ch;
      last_r <= is_last;
      bad_r  <= job_r.bad;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_char  = char_r;
  assign out_if.last_char = last_r;
  assign out_if.bad_radix = bad_r;

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (last_r && char_r == CH_NUL))
    else $error("error result must be a single NUL transaction");

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last) |=> !busy_r) else $error("job still busy after last char");

endmodule

/* tb/sv/integer_to_text_formatter_tb.sv */
`timescale 1ns / 1ps

module integer_to_text_formatter_tb;
  import ittf_pkg::*;

  // 2 ns clock, and how long reset is held
  localparam int RESET_CYCLES = 6;
  // longest legal run is 63 characters; anything past 64 is cut
  localparam int RUN_CAP      = 64;
  // receiver hold-off long enough to back the block up into its input
  localparam int HOLD_CYCLES  = 300;
  // settle time after the last expected character, to catch any extras
  localparam int DRAIN_CYCLES = 48;
  // generous ceiling on simulated time
  localparam longint TIMEOUT_NS = 64'd4_000_000;
  localparam int MAX_REPORTS  = 10;

  // flag word used by the directed items: {left, plus, space, alt, zero, lower, signed}
  localparam logic [6:0] FL_NONE   = 7'b0000000;
  localparam logic [6:0] FL_LEFT   = 7'b1000000;
  localparam logic [6:0] FL_PLUS   = 7'b0100000;
  localparam logic [6:0] FL_SPACE  = 7'b0010000;
  localparam logic [6:0] FL_ALT    = 7'b0001000;
  localparam logic [6:0] FL_ZERO   = 7'b0000100;
  localparam logic [6:0] FL_LOWER  = 7'b0000010;
  localparam logic [6:0] FL_SIGNED = 7'b0000001;

  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]           radix;
    logic [FIELD_W-1:0]           text_width;
    logic [FIELD_W-1:0]           min_digits;
    logic                         left_justify;
    logic                         force_plus;
    logic                         space_sign;
    logic                         alt_prefix;
    logic                         zero_fill;
    logic                         lower_case;
    logic                         is_signed;
  } fmt_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } text_char_t;

  // Predicts the character run for every accepted request and checks each
  // character that leaves the block against the oldest prediction.
  class text_scoreboard;
    text_char_t  pending_chars[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_request(fmt_req_t r);
      string                 digit_set;
      byte unsigned          digs[$];   // least significant first
      byte unsigned          run[$];
      logic [VALUE_BITS-1:0] mag;
      int unsigned           base;
      int                    pad;
      int                    prec;
      int                    idx;
      int                    i;
      logic                  zpad;
      byte unsigned          sign_ch;
      text_char_t            tc;

      base = r.radix;
      if (base < RADIX_MIN || base > RADIX_MAX) begin
        tc.ch   = CH_NUL;
        tc.last = 1'b1;
        tc.bad  = 1'b1;
        pending_chars.push_back(tc);
        return;
      end

      pad  = (r.text_width > MAX_FIELD) ? MAX_FIELD : int'(r.text_width);
      prec = (r.min_digits > MAX_FIELD) ? MAX_FIELD : int'(r.min_digits);
      zpad = r.zero_fill && !r.left_justify;
      digit_set = r.lower_case ? "0123456789abcdefghijklmnopqrstuvwxyz"
                               : "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

      // sign; the two's complement of the most negative value is itself,
      // which reads correctly as an unsigned magnitude
      mag     = r.value;
      sign_ch = 8'h00;
      if (r.is_signed && r.value[VALUE_BITS-1]) begin
        sign_ch = CH_MINUS;
        mag     = ~mag + 1'b1;
      end else if (r.force_plus) begin
        sign_ch = CH_PLUS;
      end else if (r.space_sign) begin
        sign_ch = CH_SPACE;
      end
      if (sign_ch != 8'h00) pad--;
      if (r.alt_prefix) begin
        if (base == 16) pad -= 2;
        else if (base == 8) pad--;
      end

      // zero still prints a single digit
      if (mag == '0) begin
        digs.push_back(CH_ZERO);
      end else begin
        while (mag != '0) begin
          idx = mag % base;
          digs.push_back(digit_set[idx]);
          mag = mag / base;
        end
      end
      if (digs.size() > prec) prec = digs.size();
      pad -= prec;

      if (!zpad && !r.left_justify) begin
        for (i = 0; i < pad; i++) run.push_back(CH_SPACE);
        pad = 0;
      end
      if (sign_ch != 8'h00) run.push_back(sign_ch);
      if (r.alt_prefix) begin
        if (base == 8) begin
          run.push_back(CH_ZERO);
        end else if (base == 16) begin
          run.push_back(CH_ZERO);
          run.push_back(digit_set[33]);
        end
      end
      if (!r.left_justify) begin
        for (i = 0; i < pad; i++) run.push_back(zpad ? CH_ZERO : CH_SPACE);
        pad = 0;
      end
      for (i = digs.size(); i < prec; i++) run.push_back(CH_ZERO);
      for (i = digs.size() - 1; i >= 0; i--) run.push_back(digs[i]);
      for (i = 0; i < pad; i++) run.push_back(CH_SPACE);
      while (run.size() > RUN_CAP) void'(run.pop_back());

      for (i = 0; i < run.size(); i++) begin
        tc.ch   = run[i];
        tc.last = (i == run.size() - 1);
        tc.bad  = 1'b0;
        pending_chars.push_back(tc);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last, logic bad);
      text_char_t exp_c;
      if (pending_chars.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("[%0t] unexpected character %02h last %0b bad %0b, nothing pending",
                   $realtime, ch, last, bad);
        mismatches++;
        return;
      end
      exp_c = pending_chars.pop_front();
      if (ch !== exp_c.ch || last !== exp_c.last || bad !== exp_c.bad) begin
        if (mismatches < MAX_REPORTS)
          $display("[%0t] mismatch: expected char %02h last %0b bad %0b, got %02h %0b %0b",
                   $realtime, exp_c.ch, exp_c.last, exp_c.bad, ch, last, bad);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ittf_in_if  in_ch ();
  ittf_out_if out_ch ();

  integer_to_text_formatter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  text_scoreboard sb;

  // idle percentages per side, changed by the stimulus between phases
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  // hold-off requests from the stimulus; the receiver process counts them out
  int unsigned holds_asked;
  int unsigned holds_done;
  int          hold_cnt;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops characters.
  initial begin
    #(TIMEOUT_NS);
    $display("integer_to_text_formatter_tb: errors");
    $finish;
  end

  // Receiver: ready changes on the falling edge only. A pending hold-off
  // request drops ready for the HOLD_CYCLES hold-off while the sender keeps
  // offering, so the job queue fills and in ready goes low.
  initial begin
    out_ch.ready = 1'b0;
    holds_done   = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        out_ch.ready <= 1'b0;
        for (hold_cnt = 1; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Output monitor: every accepted transaction goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_char(out_ch.out_char, out_ch.last_char, out_ch.bad_radix);
  end

  function automatic fmt_req_t make_req(logic [31:0] value, int radix, int fw, int md,
                                        logic [6:0] flags);
    fmt_req_t r;
    r.value        = value;
    r.radix        = RADIX_W'(radix);
    r.text_width   = FIELD_W'(fw);
    r.min_digits   = FIELD_W'(md);
    r.left_justify = |(flags & FL_LEFT);
    r.force_plus   = |(flags & FL_PLUS);
    r.space_sign   = |(flags & FL_SPACE);
    r.alt_prefix   = |(flags & FL_ALT);
    r.zero_fill    = |(flags & FL_ZERO);
    r.lower_case   = |(flags & FL_LOWER);
    r.is_signed    = |(flags & FL_SIGNED);
    return r;
  endfunction

  // Random request: mostly narrow fields, often a common base, with a share of
  // bad bases, wide fields and edge values.
  function automatic fmt_req_t random_req();
    logic [31:0] v;
    int          rdx;
    int          fw;
    int          md;
    int          pick;

    case ($urandom_range(9))
      0: v = 32'd0;
      1: v = $urandom_range(0, 99);
      2: begin
        pick = $urandom_range(3);
        v = (pick == 0) ? 32'h8000_0000 : (pick == 1) ? 32'h7FFF_FFFF :
            (pick == 2) ? 32'hFFFF_FFFF : 32'd1;
      end
      3: v = -$urandom_range(1, 1000);
      default: v = $urandom;
    endcase

    pick = $urandom_range(99);
    if (pick < 8) begin
      rdx = $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(37, 63);
    end else if (pick < 48) begin
      case ($urandom_range(4))
        0: rdx = 2;
        1: rdx = 8;
        2: rdx = 10;
        3: rdx = 16;
        default: rdx = 36;
      endcase
    end else begin
      rdx = $urandom_range(2, 36);
    end

    fw = ($urandom_range(99) < 85) ? $urandom_range(0, 24) : $urandom_range(25, 63);
    pick = $urandom_range(99);
    md = (pick < 70) ? $urandom_range(0, 3) :
         (pick < 90) ? $urandom_range(0, 14) : $urandom_range(15, 63);
    return make_req(v, rdx, fw, md, 7'($urandom));
  endfunction

  // Sender: called on a falling edge, returns on the falling edge after the
  // transaction is accepted. valid gets one assignment per edge at most.
  task automatic send_req(fmt_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.value        <= r.value;
    in_ch.radix        <= r.radix;
    in_ch.text_width   <= r.text_width;
    in_ch.min_digits   <= r.min_digits;
    in_ch.left_justify <= r.left_justify;
    in_ch.force_plus   <= r.force_plus;
    in_ch.space_sign   <= r.space_sign;
    in_ch.alt_prefix   <= r.alt_prefix;
    in_ch.zero_fill    <= r.zero_fill;
    in_ch.lower_case   <= r.lower_case;
    in_ch.is_signed    <= r.is_signed;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    repeat (count) send_req(random_req());
  endtask

  initial begin
    sb          = new();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    holds_asked = 0;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.value        = '0;
    in_ch.radix        = '0;
    in_ch.text_width   = '0;
    in_ch.min_digits   = '0;
    in_ch.left_justify = 1'b0;
    in_ch.force_plus   = 1'b0;
    in_ch.space_sign   = 1'b0;
    in_ch.alt_prefix   = 1'b0;
    in_ch.zero_fill    = 1'b0;
    in_ch.lower_case   = 1'b0;
    in_ch.is_signed    = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: sender idles lightly, receiver heavily
    tx_idle_pct = 18;
    rx_idle_pct = 62;

    // directed: zero with no precision still gives one digit
    send_req(make_req(32'd0, 10, 0, 0, FL_NONE));
    // signed extremes, the most negative value among them
    send_req(make_req(32'h7FFF_FFFF, 10, 0, 0, FL_SIGNED));
    send_req(make_req(32'h8000_0000, 10, 0, 0, FL_SIGNED));
    send_req(make_req(32'h8000_0000, 16, 0, 0, FL_NONE));
    // bad bases on both sides of the legal range
    send_req(make_req(32'd5, 0, 10, 3, FL_NONE));
    send_req(make_req(32'd5, 1, 0, 0, FL_PLUS));
    send_req(make_req(32'd5, 37, 0, 0, FL_NONE));
    send_req(make_req(32'hFFFF_FFFF, 63, 63, 63, 7'h7F));
    // base 2 full width, zero padded to a wide field
    send_req(make_req(32'hFFFF_FFFF, 2, 60, 0, FL_ZERO));
    send_req(make_req(32'hFFFF_FFFF, 36, 0, 0, FL_LOWER));
    // hex and octal prefixes, both cases
    send_req(make_req(32'hBEEF, 16, 20, 0, FL_ALT | FL_ZERO | FL_LOWER));
    send_req(make_req(32'hBEEF, 16, 20, 0, FL_ALT));
    send_req(make_req(32'o777, 8, 10, 0, FL_ALT | FL_ZERO));
    send_req(make_req(32'd0, 8, 0, 0, FL_ALT));
    // prefix ignored outside base 8 and 16
    send_req(make_req(32'd1234, 10, 8, 0, FL_ALT));
    // left align cancels zero fill
    send_req(make_req(32'hFFFF_FF85, 10, 30, 0, FL_LEFT | FL_ZERO | FL_SIGNED));
    // sign on unsigned values, plus wins over space
    send_req(make_req(32'd42, 10, 6, 0, FL_PLUS | FL_SPACE));
    send_req(make_req(32'd42, 10, 6, 0, FL_SPACE));
    // precision together with zero fill
    send_req(make_req(32'd77, 10, 12, 5, FL_ZERO | FL_PLUS));
    send_req(make_req(32'd77, 10, 12, 5, FL_LEFT));
    // oversized width and precision saturate; longest legal run
    send_req(make_req(32'hFFFF_FFFF, 16, 63, 63, FL_ALT | FL_PLUS | FL_ZERO));
    send_req(make_req(32'hFFFF_FFFF, 2, 63, 63, FL_SIGNED | FL_LEFT));
    // every flag at once
    send_req(make_req(32'hFFFF_FFFF, 2, 40, 10, 7'h7F));

    send_random(150);

    // phase 2: roles swapped
    tx_idle_pct = 62;
    rx_idle_pct = 18;
    send_random(150);

    // phase 3: no idling; start with a long receiver hold-off while the
    // sender keeps pushing, so the input side must stall
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    holds_asked = holds_asked + 1;
    send_random(160);
    in_ch.valid <= 1'b0;

    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
      $display("integer_to_text_formatter_tb: clean");
    end else begin
      $display("integer_to_text_formatter_tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ittf_pkg.sv
rtl/ittf_ifs.sv
rtl/ittf_front.sv
rtl/ittf_queue.sv
rtl/ittf_back.sv
rtl/integer_to_text_formatter.sv
tb/sv/integer_to_text_formatter_tb.sv
